// ===== sv/audio_ring_playback_rate_tuner_defines.svh =====
// Assertion macros for the audio ring playback rate tuner.
`ifndef AUDIO_RING_PLAYBACK_RATE_TUNER_DEFINES_SVH
`define AUDIO_RING_PLAYBACK_RATE_TUNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpt same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ARPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arpt next-cycle check failed");

`endif

// ===== sv/arpt_pkg.sv =====
// Shared types, codes and constants of the audio ring playback rate tuner.
package arpt_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int PERIOD_BITS_DEF = 24;

  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int DAC_W      = 17;
  localparam int FILL_W     = 10;
  localparam int PER_OUT_W  = 24;
  localparam int BSIZE_W    = 11;
  localparam int IPER_W     = 24;
  localparam int VOL_W      = 4;
  localparam int SCALE_W    = 3;
  localparam int OUT_SHIFT  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CMDQ_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAY      = 3'd2;
  localparam logic [OP_W-1:0] OP_PLAY_HALF = 3'd3;
  localparam logic [OP_W-1:0] OP_TUNE      = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd5;
  localparam logic [OP_W-1:0] OP_REINIT    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME         = 2'd2;

  localparam logic [BSIZE_W-1:0] BUFFER_SIZE_RST    = 11'd1024;
  localparam logic [IPER_W-1:0]  INITIAL_PERIOD_RST = 24'd1000;
  localparam logic [VOL_W-1:0]   VOLUME_RST         = 4'd4;
  localparam logic [VOL_W-1:0]   AMP_VOLUME         = 4'd9;

  typedef enum logic [2:0] {
    K_PUSH, K_TICK, K_PLAY, K_PLAY_HALF, K_TUNE, K_STOP, K_REINIT, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  sample;
  } cmd_t;

  // first member sits in the highest bits, so the lowest field is listed last
  typedef struct packed {
    logic [PER_OUT_W-1:0] sample_period;
    logic                 is_playing;
    logic [FILL_W-1:0]    fill_level;
    logic                 amp_enable;
    logic                 dac_written;
    logic [DAC_W-1:0]     dac_value;
  } result_t;

  localparam int RES_W = $bits(result_t);
  localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_status_t;

endpackage

// ===== sv/audio_ring_playback_rate_tuner.sv =====
// Top level of the audio ring playback rate tuner.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata sample, tuser operation
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata result fields
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One transaction per cycle while the command queue has room; a tick
// that plays a sample reads the sample store, then scales the sample into the converter value.
// The result register loads after the command leaves the queue; a playing tick adds the scale step.
// Reset clears pointers, timer and flags at once; the sample store is not cleared.
// A stalled result holds the execution stage; the queue keeps accepting until full.
module audio_ring_playback_rate_tuner #(
  parameter int RING_DEPTH  = arpt_pkg::RING_DEPTH_DEF,
  parameter int PERIOD_BITS = arpt_pkg::PERIOD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [arpt_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample
  input  logic [arpt_pkg::OP_W-1:0]          s_axis_tuser,  // [2:0] operation
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [16:0] dac_value, [17] dac_written, [18] amp_enable, [28:19] fill_level,
  // [29] is_playing, [53:30] sample_period, [55:54] zero
  output logic [arpt_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [arpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "audio_ring_playback_rate_tuner_defines.svh"

  logic                   fr_valid;
  logic                   fr_ready;
  arpt_pkg::cmd_t         fr_cmd;
  logic                   q_valid;
  logic                   q_ready;
  arpt_pkg::cmd_t         q_cmd;
  arpt_pkg::result_t      result;
  arpt_pkg::back_status_t bk_status;

  arpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_sample (s_axis_tdata),
    .q_valid   (fr_valid),
    .q_ready   (fr_ready),
    .q_cmd     (fr_cmd)
  );

  arpt_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  arpt_back #(
    .RING_DEPTH  (RING_DEPTH),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (result),
    .status    (bk_status)
  );

  assign m_axis_tdata = {{(arpt_pkg::TDATA_OUT_W - arpt_pkg::RES_W){1'b0}}, result};

  `ARPT_ASSERT_NOW(a_no_pop_when_stalled, bk_status.pop, !m_axis_tvalid || m_axis_tready)
  `ARPT_ASSERT_NOW(a_play_slot_free, bk_status.busy, !m_axis_tvalid)
  `ARPT_ASSERT_NEXT(a_play_delivers, bk_status.busy, m_axis_tvalid)
  `ARPT_ASSERT_NOW(a_period_nonzero, m_axis_tvalid && (PERIOD_BITS <= 24), m_axis_tdata[53:30] != '0)

endmodule

// ===== sv/arpt_front.sv =====
// Input stage: accepts stream transactions and classifies the operation code.
module arpt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arpt_pkg::OP_W-1:0]     in_op,
  input  logic [arpt_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          q_valid,
  input  logic                          q_ready,
  output arpt_pkg::cmd_t                q_cmd
);

  logic           hold_valid;
  arpt_pkg::cmd_t hold_cmd;
  arpt_pkg::kind_t kind_dec;

  always_comb begin
    unique case (in_op)
      arpt_pkg::OP_PUSH:      kind_dec = arpt_pkg::K_PUSH;
      arpt_pkg::OP_TICK:      kind_dec = arpt_pkg::K_TICK;
      arpt_pkg::OP_PLAY:      kind_dec = arpt_pkg::K_PLAY;
      arpt_pkg::OP_PLAY_HALF: kind_dec = arpt_pkg::K_PLAY_HALF;
      arpt_pkg::OP_TUNE:      kind_dec = arpt_pkg::K_TUNE;
      arpt_pkg::OP_STOP:      kind_dec = arpt_pkg::K_STOP;
      arpt_pkg::OP_REINIT:    kind_dec = arpt_pkg::K_REINIT;
      default:                kind_dec = arpt_pkg::K_NOP;
    endcase
  end

  assign in_ready = !hold_valid || q_ready;
  assign q_valid  = hold_valid;
  assign q_cmd    = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_cmd.kind   <= kind_dec;
      hold_cmd.sample <= in_sample;
    end
  end

endmodule

// ===== sv/arpt_cmd_queue.sv =====
// Short command queue between the input stage and the execution stage.
module arpt_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  arpt_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output arpt_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = $clog2(arpt_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(arpt_pkg::CMDQ_DEPTH + 1);

  arpt_pkg::cmd_t   entries [arpt_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != CNT_W'(arpt_pkg::CMDQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(arpt_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(arpt_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== sv/arpt_back.sv =====
// Execution stage: sample ring, timer, rate tuning, configuration and result register.
module arpt_back #(
  parameter int RING_DEPTH  = arpt_pkg::RING_DEPTH_DEF,
  parameter int PERIOD_BITS = arpt_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [arpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  arpt_pkg::cmd_t                  q_cmd,
  output logic                            res_valid,
  input  logic                            res_ready,
  output arpt_pkg::result_t               res,
  output arpt_pkg::back_status_t          status
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int SIZE_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W  = (SIZE_W > arpt_pkg::BSIZE_W) ? SIZE_W : arpt_pkg::BSIZE_W;
  localparam int FEXT_W = (SIZE_W > arpt_pkg::FILL_W) ? SIZE_W : arpt_pkg::FILL_W;
  localparam int PEXT_W = (PERIOD_BITS > arpt_pkg::PER_OUT_W) ? PERIOD_BITS
                                                              : arpt_pkg::PER_OUT_W;
  localparam int PROD_W = arpt_pkg::SAMPLE_W + arpt_pkg::SCALE_W;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

  typedef enum logic {S_RUN, S_PLAY} state_t;

  function automatic logic [PERIOD_BITS-1:0] load_period(input logic [arpt_pkg::IPER_W-1:0] ip);
    logic [PERIOD_BITS-1:0] p;
    p = PERIOD_BITS'(ip);
    return (p == '0) ? PERIOD_BITS'(1) : p;
  endfunction

  function automatic logic [SIZE_W-1:0] fill_of(input logic [IDX_W-1:0] w,
                                                input logic [IDX_W-1:0] r,
                                                input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] f;
    if (w < r) begin
      f = SIZE_W'(w) + (sz - SIZE_W'(r));
    end else begin
      f = SIZE_W'(w) - SIZE_W'(r);
    end
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] n;
    n = SIZE_W'(idx) + SIZE_W'(1);
    return (n >= sz) ? '0 : n[IDX_W-1:0];
  endfunction

  logic [arpt_pkg::SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [arpt_pkg::SAMPLE_W-1:0] mem_q;

  logic [arpt_pkg::BSIZE_W-1:0] buffer_size;
  logic [arpt_pkg::IPER_W-1:0]  initial_period;
  logic [arpt_pkg::VOL_W-1:0]   volume;

  state_t                 state;
  logic [IDX_W-1:0]       wi, wi_next;
  logic [IDX_W-1:0]       ri, ri_next;
  logic                   playing, playing_next;
  logic                   timer_on, timer_on_next;
  logic [PERIOD_BITS-1:0] tick, tick_next;
  logic [PERIOD_BITS-1:0] period_now, period_next;
  logic [arpt_pkg::DAC_W-1:0] last_output, last_output_next;
  arpt_pkg::result_t      res_next;

  logic                   pop;
  logic                   written;
  logic                   to_play;
  logic [CMP_W-1:0]       bs_ext;
  logic [SIZE_W-1:0]      size;
  logic [SIZE_W-1:0]      fill_now;
  logic signed [SIZE_W+1:0] fill_sx;
  logic signed [SIZE_W+1:0] half_s;
  logic signed [SIZE_W+1:0] quarter_s;
  logic [PERIOD_BITS-1:0] tick_inc;
  logic [PROD_W-1:0]      prod;
  logic [FEXT_W-1:0]      fill_ext;
  logic [PEXT_W-1:0]      period_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size    <= arpt_pkg::BUFFER_SIZE_RST;
      initial_period <= arpt_pkg::INITIAL_PERIOD_RST;
      volume         <= arpt_pkg::VOLUME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        arpt_pkg::CFG_BUFFER_SIZE:    buffer_size    <= cfg_data[arpt_pkg::BSIZE_W-1:0];
        arpt_pkg::CFG_INITIAL_PERIOD: initial_period <= cfg_data[arpt_pkg::IPER_W-1:0];
        arpt_pkg::CFG_VOLUME:         volume         <= cfg_data[arpt_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bs_ext = CMP_W'(buffer_size);
    if (bs_ext < CMP_W'(2)) begin
      size = SIZE_W'(2);
    end else if (bs_ext > CMP_W'(RING_DEPTH)) begin
      size = SIZE_W'(RING_DEPTH);
    end else begin
      size = bs_ext[SIZE_W-1:0];
    end
  end

  // signed fill: negative when the read index lies beyond a shrunken ring
  assign fill_now     = fill_of(wi, ri, size);
  assign fill_sx      = (wi < ri)
                        ? $signed((SIZE_W+2)'(wi) + (SIZE_W+2)'(size) - (SIZE_W+2)'(ri))
                        : $signed((SIZE_W+2)'(wi) - (SIZE_W+2)'(ri));
  assign half_s       = $signed((SIZE_W+2)'(size >> 1));
  assign quarter_s    = $signed((SIZE_W+2)'(size >> 2));
  assign tick_inc     = tick + PERIOD_BITS'(1);
  assign prod         = PROD_W'(mem_q) * PROD_W'(volume[arpt_pkg::SCALE_W-1:0]);
  assign q_ready      = (state == S_RUN) && (!res_valid || res_ready);
  assign pop          = q_valid && q_ready;

  always_comb begin
    wi_next          = wi;
    ri_next          = ri;
    playing_next     = playing;
    timer_on_next    = timer_on;
    tick_next        = tick;
    period_next      = period_now;
    last_output_next = last_output;
    written          = 1'b0;
    to_play          = 1'b0;
    if (state == S_PLAY) begin
      last_output_next = prod[PROD_W-1:arpt_pkg::OUT_SHIFT];
      written          = 1'b1;
    end else if (pop) begin
      unique case (q_cmd.kind)
        arpt_pkg::K_PUSH: begin
          wi_next = advance(wi, size);
        end
        arpt_pkg::K_TICK: begin
          if (timer_on) begin
            if (tick_inc >= period_now) begin
              tick_next = '0;
              if (playing && (ri != wi)) begin
                ri_next = advance(ri, size);
                to_play = 1'b1;
              end
            end else begin
              tick_next = tick_inc;
            end
          end
        end
        arpt_pkg::K_PLAY: begin
          playing_next = 1'b1;
        end
        arpt_pkg::K_PLAY_HALF: begin
          if (!playing && ((fill_sx < 0) || ({fill_now, 1'b0} >= {1'b0, size}))) begin
            playing_next = 1'b1;
          end
        end
        arpt_pkg::K_TUNE: begin
          if ((fill_sx + quarter_s) < half_s) begin
            if (period_now < PERIOD_MAX) begin
              period_next = period_now + PERIOD_BITS'(1);
            end
          end
          if (fill_sx > (half_s + quarter_s)) begin
            period_next = (period_now > PERIOD_BITS'(1)) ? period_now - PERIOD_BITS'(1)
                                                         : PERIOD_BITS'(1);
          end
        end
        arpt_pkg::K_STOP: begin
          timer_on_next    = 1'b0;
          last_output_next = '0;
          written          = 1'b1;
        end
        arpt_pkg::K_REINIT: begin
          wi_next       = '0;
          ri_next       = '0;
          playing_next  = 1'b0;
          timer_on_next = 1'b1;
          tick_next     = '0;
          period_next   = load_period(initial_period);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_ext   = FEXT_W'(fill_of(wi_next, ri_next, size));
    period_ext = PEXT_W'(period_next);
    res_next.dac_value     = last_output_next;
    res_next.dac_written   = written;
    res_next.amp_enable    = (volume == arpt_pkg::AMP_VOLUME) && timer_on_next;
    res_next.fill_level    = fill_ext[arpt_pkg::FILL_W-1:0];
    res_next.is_playing    = playing_next;
    res_next.sample_period = period_ext[arpt_pkg::PER_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop && (q_cmd.kind == arpt_pkg::K_PUSH)) begin
      mem[wi] <= q_cmd.sample;
    end
    if (pop) begin
      mem_q <= mem[ri];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      res_valid   <= 1'b0;
      wi          <= '0;
      ri          <= '0;
      playing     <= 1'b0;
      timer_on    <= 1'b1;
      tick        <= '0;
      period_now  <= load_period(arpt_pkg::INITIAL_PERIOD_RST);
      last_output <= '0;
    end else begin
      wi          <= wi_next;
      ri          <= ri_next;
      playing     <= playing_next;
      timer_on    <= timer_on_next;
      tick        <= tick_next;
      period_now  <= period_next;
      last_output <= last_output_next;
      unique case (state)
        S_PLAY:  state <= S_RUN;
        default: state <= to_play ? S_PLAY : S_RUN;
      endcase
      if ((state == S_PLAY) || (pop && !to_play)) begin
        res_valid <= 1'b1;
        res       <= res_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign status.pop  = pop;
  assign status.busy = (state == S_PLAY);

endmodule
